/* rtl/rcpq_pkg.sv */
package rcpq_pkg;

    // Fixed field widths
    localparam int TIMER_BITS = 16;
    localparam int CH_W       = 2;
    localparam int NORM_W     = 16;
    localparam int MOTOR_W    = 18;
    localparam int MOTORS     = 4;
    localparam int CFG_IDX_W  = 3;
    localparam int DIV_STEPS  = NORM_W;

    // Receiver channel codes
    localparam logic [CH_W-1:0] CH_YAW   = 2'd0;
    localparam logic [CH_W-1:0] CH_LIFT  = 2'd1;
    localparam logic [CH_W-1:0] CH_PITCH = 2'd2;
    localparam logic [CH_W-1:0] CH_ROLL  = 2'd3;

    // Register indexes
    localparam logic [CFG_IDX_W-1:0] REG_PERIOD    = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_LIFT_MIN  = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_LIFT_MAX  = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_PITCH_MIN = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_PITCH_MAX = 3'd4;
    localparam logic [CFG_IDX_W-1:0] REG_STICK_MIN = 3'd5;
    localparam logic [CFG_IDX_W-1:0] REG_STICK_MAX = 3'd6;

    // Reset values
    localparam logic [TIMER_BITS-1:0] PERIOD_RESET = 16'd65535;
    localparam logic [TIMER_BITS-1:0] MIN_RESET    = 16'd1000;
    localparam logic [TIMER_BITS-1:0] MAX_RESET    = 16'd2000;
    // mid-stick for yaw, pitch, roll; zero for lift
    localparam logic [3:0][NORM_W-1:0] NORM_RESET =
        {16'd16384, 16'd16384, 16'd0, 16'd16384};

    // Quad-X mixing: bit m set means motor m takes the change negated
    localparam logic [3:0][MOTORS-1:0] MIX_NEG = {
        4'b0101,   // roll  - + - +
        4'b1100,   // pitch + + - -
        4'b0000,   // lift  + + + +
        4'b0110    // yaw   + - - +
    };

    typedef logic [MOTORS-1:0][MOTOR_W-1:0] motor_vec_t;

    typedef struct packed {
        logic                  start;
        logic [NORM_W-1:0]     num;
        logic [NORM_W-1:0]     den;
    } div_req_t;

    typedef struct packed {
        logic                  done;
        logic [NORM_W-1:0]     quot;
    } div_stat_t;

    typedef struct packed {
        logic                  start;
        logic [CH_W-1:0]       ch;
        logic [NORM_W:0]       delta;   // two's complement
    } mix_req_t;

    typedef struct packed {
        logic                  done;
        motor_vec_t            motors;
    } mix_stat_t;

endpackage

/* rtl/rc_pulse_capture_quad_mixer.sv */
// Channel  Dir  Beat fields (low bit first)
// s_axis   in   tuser: channel[1:0]; tdata: capture_value[15:0]
// m_axis   out  tuser: source_channel[1:0]; tdata: pulse_width[15:0],
//               motor_one[33:16], motor_two[51:34], motor_three[69:52],
//               motor_four[87:70]
// cfg      in   cfg_index[2:0], cfg_data[15:0]; always ready
//
// A rising capture only stores its timer value and leaves the block idle.
// A falling capture runs clamp, 16 divider steps, delta, four passes of the
// shared motor adder, then the output load. An empty or inverted range skips
// the divider.
// Reset puts every channel on its rising edge and clears the motor levels.
// The output register holds a result under back-pressure; the next beat is
// still accepted, and its result waits until the held one is taken.
module rc_pulse_capture_quad_mixer (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [15:0] s_axis_tdata,   // capture_value
    input  logic [1:0]  s_axis_tuser,   // channel
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [87:0] m_axis_tdata,   // pulse_width, motor_one..motor_four
    output logic [1:0]  m_axis_tuser,   // source_channel
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [rcpq_pkg::CFG_IDX_W-1:0] cfg_index,
    input  logic [15:0] cfg_data
);
    import rcpq_pkg::*;

    localparam logic [2:0] ST_IDLE  = 3'd0;
    localparam logic [2:0] ST_CLAMP = 3'd1;
    localparam logic [2:0] ST_DIV   = 3'd2;
    localparam logic [2:0] ST_DELTA = 3'd3;
    localparam logic [2:0] ST_MIX   = 3'd4;
    localparam logic [2:0] ST_OUT   = 3'd5;

    logic [2:0]                    state_reg, state_next;
    logic [TIMER_BITS-1:0]         period_reg;
    logic [TIMER_BITS-1:0]         lift_min_reg, lift_max_reg;
    logic [TIMER_BITS-1:0]         pitch_min_reg, pitch_max_reg;
    logic [TIMER_BITS-1:0]         stick_min_reg, stick_max_reg;
    logic [3:0][TIMER_BITS-1:0]    rise_reg;
    logic [3:0]                    expect_rise_reg;
    logic [3:0][NORM_W-1:0]        last_norm_reg;
    logic [CH_W-1:0]               ch_reg;
    logic [TIMER_BITS-1:0]         width_reg, width_next;
    logic [NORM_W-1:0]             norm_reg, norm_next;
    logic                          out_valid_reg, out_valid_next;
    logic [CH_W-1:0]               out_ch_reg;
    logic [TIMER_BITS-1:0]         out_width_reg;
    motor_vec_t                    out_motor_reg;

    logic                          s_fire;
    logic                          out_load;
    logic [TIMER_BITS-1:0]         rise;
    logic [TIMER_BITS-1:0]         lo, hi, wc;
    logic                          span_empty;
    logic [NORM_W:0]               delta;
    div_req_t                      div_req;
    div_stat_t                     div_stat;
    mix_req_t                      mix_req;
    mix_stat_t                     mix_stat;

    assign s_axis_tready = (state_reg == ST_IDLE);
    assign s_fire        = s_axis_tvalid && s_axis_tready;
    assign cfg_ready     = 1'b1;
    assign out_load      = (state_reg == ST_OUT) && (!out_valid_reg || m_axis_tready);

    // Width with counter-wrap correction
    always_comb
    begin
        rise = rise_reg[s_axis_tuser];
        if (s_axis_tdata >= rise)
            width_next = s_axis_tdata - rise;
        else
            width_next = (period_reg - rise) + s_axis_tdata;
    end

    // Range select and clamp
    always_comb
    begin
        case (ch_reg)
            CH_LIFT:
            begin
                lo = lift_min_reg;
                hi = lift_max_reg;
            end
            CH_PITCH:
            begin
                lo = pitch_min_reg;
                hi = pitch_max_reg;
            end
            default:
            begin
                lo = stick_min_reg;
                hi = stick_max_reg;
            end
        endcase
        span_empty = (hi <= lo);
        if (width_reg < lo)
            wc = lo;
        else if (width_reg > hi)
            wc = hi;
        else
            wc = width_reg;
    end

    assign div_req.start = (state_reg == ST_CLAMP) && !span_empty;
    assign div_req.num   = wc - lo;
    assign div_req.den   = hi - lo;

    assign delta         = {1'b0, norm_reg} - {1'b0, last_norm_reg[ch_reg]};
    assign mix_req.start = (state_reg == ST_DELTA);
    assign mix_req.ch    = ch_reg;
    assign mix_req.delta = delta;

    rcpq_div u_div (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (div_req),
        .stat  (div_stat)
    );

    rcpq_mix u_mix (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (mix_req),
        .stat  (mix_stat)
    );

    // Sequencer
    always_comb
    begin
        state_next = state_reg;
        norm_next  = norm_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (s_fire && !expect_rise_reg[s_axis_tuser])
                    state_next = ST_CLAMP;
            end
            ST_CLAMP:
            begin
                if (span_empty)
                begin
                    norm_next  = '0;
                    state_next = ST_DELTA;
                end
                else
                    state_next = ST_DIV;
            end
            ST_DIV:
            begin
                if (div_stat.done)
                begin
                    norm_next  = div_stat.quot;
                    state_next = ST_DELTA;
                end
            end
            ST_DELTA:
                state_next = ST_MIX;
            ST_MIX:
            begin
                if (mix_stat.done)
                    state_next = ST_OUT;
            end
            ST_OUT:
            begin
                if (out_load)
                    state_next = ST_IDLE;
            end
            default:
                state_next = ST_IDLE;
        endcase
    end

    // Output beat holding register
    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (out_load)
            out_valid_next = 1'b1;
        else if (m_axis_tready)
            out_valid_next = 1'b0;
    end

    // Control state, configuration and per-channel edge tracking
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg       <= ST_IDLE;
            out_valid_reg   <= 1'b0;
            expect_rise_reg <= '1;
            last_norm_reg   <= NORM_RESET;
            period_reg      <= PERIOD_RESET;
            lift_min_reg    <= MIN_RESET;
            lift_max_reg    <= MAX_RESET;
            pitch_min_reg   <= MIN_RESET;
            pitch_max_reg   <= MAX_RESET;
            stick_min_reg   <= MIN_RESET;
            stick_max_reg   <= MAX_RESET;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
            if (s_fire)
                expect_rise_reg[s_axis_tuser] <= !expect_rise_reg[s_axis_tuser];
            if (state_reg == ST_DELTA)
                last_norm_reg[ch_reg] <= norm_reg;
            if (cfg_valid && cfg_ready)
            begin
                case (cfg_index)
                    REG_PERIOD:    period_reg    <= cfg_data;
                    REG_LIFT_MIN:  lift_min_reg  <= cfg_data;
                    REG_LIFT_MAX:  lift_max_reg  <= cfg_data;
                    REG_PITCH_MIN: pitch_min_reg <= cfg_data;
                    REG_PITCH_MAX: pitch_max_reg <= cfg_data;
                    REG_STICK_MIN: stick_min_reg <= cfg_data;
                    REG_STICK_MAX: stick_max_reg <= cfg_data;
                    default:       ;
                endcase
            end
        end
    end

    // Payload registers
    always_ff @(posedge clk)
    begin
        if (s_fire)
        begin
            ch_reg    <= s_axis_tuser;
            width_reg <= width_next;
            if (expect_rise_reg[s_axis_tuser])
                rise_reg[s_axis_tuser] <= s_axis_tdata;
        end
        norm_reg <= norm_next;
        if (out_load)
        begin
            out_ch_reg    <= ch_reg;
            out_width_reg <= width_reg;
            out_motor_reg <= mix_stat.motors;
        end
    end

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tuser  = out_ch_reg;
    assign m_axis_tdata  = {out_motor_reg[3], out_motor_reg[2], out_motor_reg[1],
                            out_motor_reg[0], out_width_reg};

    // A falling capture always starts the measurement pass
    a_fall_starts: assert property (@(posedge clk) disable iff (!rst_n)
        (s_fire && !expect_rise_reg[s_axis_tuser]) |=> (state_reg == ST_CLAMP))
        else $error("falling capture did not start a measurement");

    // A rising capture gives no result and leaves the block ready
    a_rise_quiet: assert property (@(posedge clk) disable iff (!rst_n)
        (s_fire && expect_rise_reg[s_axis_tuser]) |=> (state_reg == ST_IDLE))
        else $error("rising capture left idle");

    // Divider results only arrive while the sequencer waits for them
    a_div_in_state: assert property (@(posedge clk) disable iff (!rst_n)
        div_stat.done |-> (state_reg == ST_DIV))
        else $error("divider result outside divide state");

    // A new output beat is only raised from the output state
    a_out_source: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(m_axis_tvalid) |-> ($past(state_reg) == ST_OUT))
        else $error("output beat raised outside output state");

endmodule

/* rtl/rcpq_div.sv */
module rcpq_div (
    input  logic               clk,
    input  logic               rst_n,
    input  rcpq_pkg::div_req_t  req,
    output rcpq_pkg::div_stat_t stat
);
    import rcpq_pkg::*;

    localparam int CNT_W = $clog2(DIV_STEPS);

    logic              busy_reg, busy_next;
    logic              done_reg, done_next;
    logic [CNT_W-1:0]  cnt_reg, cnt_next;
    logic [NORM_W:0]   rem_reg, rem_next;
    logic [NORM_W-1:0] den_reg, den_next;
    logic [NORM_W-1:0] quot_reg, quot_next;
    logic              ge;
    logic [NORM_W:0]   diff;

    // Restoring divide of num * 2^15 by den, one quotient bit a cycle.
    // num never exceeds den, so the first step needs no shift.
    always_comb
    begin
        ge        = (rem_reg >= {1'b0, den_reg});
        diff      = ge ? (rem_reg - {1'b0, den_reg}) : rem_reg;
        busy_next = busy_reg;
        done_next = 1'b0;
        cnt_next  = cnt_reg;
        rem_next  = rem_reg;
        den_next  = den_reg;
        quot_next = quot_reg;
        if (req.start)
        begin
            busy_next = 1'b1;
            cnt_next  = '0;
            rem_next  = {1'b0, req.num};
            den_next  = req.den;
            quot_next = '0;
        end
        else if (busy_reg)
        begin
            rem_next  = {diff[NORM_W-1:0], 1'b0};
            quot_next = {quot_reg[NORM_W-2:0], ge};
            cnt_next  = cnt_reg + 1'b1;
            if (cnt_reg == CNT_W'(DIV_STEPS - 1))
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        rem_reg  <= rem_next;
        den_reg  <= den_next;
        quot_reg <= quot_next;
    end

    assign stat.done = done_reg;
    assign stat.quot = quot_reg;

    // Quotient of a value no larger than the divisor stays within 1.0
    a_quot_range: assert property (@(posedge clk) disable iff (!rst_n)
        done_reg |-> (quot_reg <= 16'd32768))
        else $error("divider quotient above 1.0");

    // Done is raised only as busy falls after the last step
    a_done_after_busy: assert property (@(posedge clk) disable iff (!rst_n)
        done_reg |-> ($past(busy_reg) && !busy_reg))
        else $error("divider done without finishing");

    // Start is never issued while a divide is running
    a_no_restart: assert property (@(posedge clk) disable iff (!rst_n)
        busy_reg |-> !req.start)
        else $error("divider restarted while busy");

endmodule

/* rtl/rcpq_mix.sv */
module rcpq_mix (
    input  logic               clk,
    input  logic               rst_n,
    input  rcpq_pkg::mix_req_t  req,
    output rcpq_pkg::mix_stat_t stat
);
    import rcpq_pkg::*;

    localparam int IDX_W = $clog2(MOTORS);

    motor_vec_t          motor_reg, motor_next;
    logic                busy_reg, busy_next;
    logic                done_reg, done_next;
    logic [IDX_W-1:0]    idx_reg, idx_next;
    logic [CH_W-1:0]     ch_reg, ch_next;
    logic [MOTOR_W-1:0]  delta_reg, delta_next;
    logic [MOTOR_W-1:0]  acc;

    // One shared add/subtract walks the four accumulators in turn
    always_comb
    begin
        acc = MIX_NEG[ch_reg][idx_reg] ? (motor_reg[idx_reg] - delta_reg)
                                       : (motor_reg[idx_reg] + delta_reg);
        motor_next = motor_reg;
        busy_next  = busy_reg;
        done_next  = 1'b0;
        idx_next   = idx_reg;
        ch_next    = ch_reg;
        delta_next = delta_reg;
        if (req.start)
        begin
            busy_next  = 1'b1;
            idx_next   = '0;
            ch_next    = req.ch;
            delta_next = {req.delta[NORM_W], req.delta};
        end
        else if (busy_reg)
        begin
            motor_next[idx_reg] = acc;
            idx_next = idx_reg + 1'b1;
            if (idx_reg == IDX_W'(MOTORS - 1))
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            motor_reg <= '0;
            busy_reg  <= 1'b0;
            done_reg  <= 1'b0;
            idx_reg   <= '0;
        end
        else
        begin
            motor_reg <= motor_next;
            busy_reg  <= busy_next;
            done_reg  <= done_next;
            idx_reg   <= idx_next;
        end
    end

    always_ff @(posedge clk)
    begin
        ch_reg    <= ch_next;
        delta_reg <= delta_next;
    end

    assign stat.done   = done_reg;
    assign stat.motors = motor_reg;

    // Accumulators only move while a mix pass runs
    a_motor_hold: assert property (@(posedge clk) disable iff (!rst_n)
        !busy_reg |=> (motor_reg == $past(motor_reg)))
        else $error("motor level changed outside a mix pass");

    // Done follows the last of the four updates
    a_done_after_last: assert property (@(posedge clk) disable iff (!rst_n)
        done_reg |-> ($past(busy_reg) && ($past(idx_reg) == IDX_W'(MOTORS - 1))))
        else $error("mix pass ended early");

    a_no_restart: assert property (@(posedge clk) disable iff (!rst_n)
        busy_reg |-> !req.start)
        else $error("mixer restarted while busy");

endmodule
